// ----- sv/csc_pkg.sv -----
// ----------------------------------------------------------------------------
// Conveyor sort controller package
// Shared types, state encoding and constants for the sorting controller.
// ----------------------------------------------------------------------------
package csc_pkg;

  localparam int unsigned CodeW    = 4;
  localparam int unsigned VerdictW = 2;

  // Profile checker verdict codes.
  localparam logic [VerdictW-1:0] VERDICT_ACCEPT = 2'd1;
  localparam logic [VerdictW-1:0] VERDICT_ERROR  = 2'd2;

  // Numeric state codes as seen on the result channel.
  localparam logic [CodeW-1:0] CODE_START      = 4'd0;
  localparam logic [CodeW-1:0] CODE_STANDBY    = 4'd1;
  localparam logic [CodeW-1:0] CODE_READY      = 4'd2;
  localparam logic [CodeW-1:0] CODE_TRANSPORT  = 4'd3;
  localparam logic [CodeW-1:0] CODE_METALDET   = 4'd4;
  localparam logic [CodeW-1:0] CODE_NONMETAL   = 4'd5;
  localparam logic [CodeW-1:0] CODE_ENDREACHED = 4'd6;
  localparam logic [CodeW-1:0] CODE_METAL      = 4'd7;
  localparam logic [CodeW-1:0] CODE_SLIDE      = 4'd8;
  localparam logic [CodeW-1:0] CODE_ERROR      = 4'd9;
  localparam logic [CodeW-1:0] CODE_PROFDET    = 4'd10;
  localparam logic [CodeW-1:0] CODE_PROFBAD    = 4'd11;
  localparam logic [CodeW-1:0] CODE_PROFOK     = 4'd12;

  // Sorting state, one-hot.
  typedef enum logic [12:0] {
    S_START      = 13'b0000000000001,
    S_STANDBY    = 13'b0000000000010,
    S_READY      = 13'b0000000000100,
    S_TRANSPORT  = 13'b0000000001000,
    S_METALDET   = 13'b0000000010000,
    S_NONMETAL   = 13'b0000000100000,
    S_ENDREACHED = 13'b0000001000000,
    S_METAL      = 13'b0000010000000,
    S_SLIDE      = 13'b0000100000000,
    S_ERROR      = 13'b0001000000000,
    S_PROFDET    = 13'b0010000000000,
    S_PROFBAD    = 13'b0100000000000,
    S_PROFOK     = 13'b1000000000000
  } sort_state_t;

  // One sensor request as held in the input register.
  typedef struct packed {
    logic                start_released;
    logic                item_at_start;
    logic                item_at_end;
    logic                item_at_height;
    logic                item_at_metal;
    logic                metal_found;
    logic                item_past_slide;
    logic                profile_done;
    logic [VerdictW-1:0] profile_verdict;
    logic                blink_phase;
  } sensors_t;

  // Actuator outputs, held between requests.
  typedef struct packed {
    logic drive_right;
    logic lamp_green;
    logic lamp_red;
    logic lamp_yellow;
    logic start_led;
    logic gate_open;
  } actuators_t;

  function automatic logic [CodeW-1:0] state_code_of(input sort_state_t s);
    logic [CodeW-1:0] c;
    case (s)
      S_START:      c = CODE_START;
      S_STANDBY:    c = CODE_STANDBY;
      S_READY:      c = CODE_READY;
      S_TRANSPORT:  c = CODE_TRANSPORT;
      S_METALDET:   c = CODE_METALDET;
      S_NONMETAL:   c = CODE_NONMETAL;
      S_ENDREACHED: c = CODE_ENDREACHED;
      S_METAL:      c = CODE_METAL;
      S_SLIDE:      c = CODE_SLIDE;
      S_ERROR:      c = CODE_ERROR;
      S_PROFDET:    c = CODE_PROFDET;
      S_PROFBAD:    c = CODE_PROFBAD;
      S_PROFOK:     c = CODE_PROFOK;
      default:      c = CODE_START;
    endcase
    return c;
  endfunction

endpackage

// ----- sv/csc_if.sv -----
// ----------------------------------------------------------------------------
// Conveyor sort controller channels
// Valid/ready channels for sensor requests and controller results.
// ----------------------------------------------------------------------------
interface csc_sensor_if;
  logic       valid;
  logic       ready;
  logic       start_released;
  logic       item_at_start;
  logic       item_at_end;
  logic       item_at_height;
  logic       item_at_metal;
  logic       metal_found;
  logic       item_past_slide;
  logic       profile_done;
  logic [1:0] profile_verdict;
  logic       blink_phase;

  modport source (
    output valid, start_released, item_at_start, item_at_end, item_at_height,
           item_at_metal, metal_found, item_past_slide, profile_done,
           profile_verdict, blink_phase,
    input  ready
  );
  modport sink (
    input  valid, start_released, item_at_start, item_at_end, item_at_height,
           item_at_metal, metal_found, item_past_slide, profile_done,
           profile_verdict, blink_phase,
    output ready
  );
endinterface

interface csc_result_if;
  logic       valid;
  logic       ready;
  logic [3:0] state_code;
  logic       drive_right;
  logic       lamp_green;
  logic       lamp_red;
  logic       lamp_yellow;
  logic       start_led;
  logic       gate_open;

  modport source (
    output valid, state_code, drive_right, lamp_green, lamp_red, lamp_yellow,
           start_led, gate_open,
    input  ready
  );
  modport sink (
    input  valid, state_code, drive_right, lamp_green, lamp_red, lamp_yellow,
           start_led, gate_open,
    output ready
  );
endinterface

// ----- sv/csc_next_state.sv -----
// ----------------------------------------------------------------------------
// Conveyor sort controller next-state logic
// Works out the following sorting state from the current one and the sensors.
// ----------------------------------------------------------------------------
module csc_next_state (
  input  csc_pkg::sort_state_t state,
  input  csc_pkg::sensors_t    sensors,
  output csc_pkg::sort_state_t state_next
);
  import csc_pkg::*;

  // Within one state, a later condition overrides an earlier one.
  always_comb begin
    state_next = state;
    case (state)
      S_START: begin
        state_next = S_STANDBY;
      end
      S_STANDBY: begin
        if (sensors.start_released) state_next = S_READY;
      end
      S_READY: begin
        if (sensors.start_released) state_next = S_STANDBY;
        if (sensors.item_at_start && !sensors.item_at_end) state_next = S_TRANSPORT;
        if (sensors.item_at_height || sensors.item_at_metal) state_next = S_ERROR;
      end
      S_TRANSPORT: begin
        if (sensors.item_at_metal) state_next = S_METALDET;
        if (sensors.item_at_end) state_next = S_ERROR;
      end
      S_METALDET: begin
        state_next = sensors.metal_found ? S_METAL : S_NONMETAL;
      end
      S_NONMETAL: begin
        if (sensors.item_at_height) state_next = S_PROFDET;
      end
      S_ENDREACHED: begin
        if (sensors.start_released) state_next = S_STANDBY;
        if (!sensors.item_at_end) state_next = S_READY;
        if (sensors.item_at_metal || sensors.item_at_height) state_next = S_ERROR;
      end
      S_METAL: begin
        if (sensors.item_past_slide) state_next = S_SLIDE;
        if (sensors.item_at_start || sensors.item_at_height) state_next = S_ERROR;
      end
      S_SLIDE: begin
        if (sensors.start_released) state_next = S_STANDBY;
        if (sensors.item_at_start) state_next = S_TRANSPORT;
        if (sensors.item_at_end || sensors.item_at_height) state_next = S_ERROR;
      end
      S_ERROR: begin
        if (sensors.start_released) state_next = S_STANDBY;
      end
      S_PROFDET: begin
        if (sensors.profile_done && sensors.profile_verdict == VERDICT_ACCEPT) begin
          state_next = S_PROFOK;
        end
        if (sensors.profile_done && sensors.profile_verdict == VERDICT_ERROR) begin
          state_next = S_PROFBAD;
        end
      end
      S_PROFBAD: begin
        if (sensors.item_at_start) state_next = S_READY;
      end
      S_PROFOK: begin
        if (sensors.item_at_end) state_next = S_ENDREACHED;
      end
      default: begin
        state_next = S_START;
      end
    endcase
  end

endmodule

// ----- sv/csc_actuators.sv -----
// ----------------------------------------------------------------------------
// Conveyor sort controller actuator logic
// Sets the belt drive, lamps, start LED and gate for the new sorting state.
// ----------------------------------------------------------------------------
module csc_actuators (
  input  csc_pkg::sort_state_t state_next,
  input  csc_pkg::actuators_t  act,
  input  logic                 blink_phase,
  output csc_pkg::actuators_t  act_next
);
  import csc_pkg::*;

  // Anything a state leaves alone keeps its previous value.
  always_comb begin
    act_next = act;
    case (state_next)
      S_START, S_STANDBY: begin
        act_next.drive_right = 1'b0;
        act_next.lamp_green  = 1'b0;
        act_next.lamp_red    = 1'b0;
        act_next.lamp_yellow = 1'b0;
        act_next.start_led   = 1'b1;
      end
      S_READY, S_SLIDE: begin
        act_next.drive_right = 1'b0;
        act_next.lamp_red    = 1'b0;
        act_next.lamp_yellow = 1'b0;
        act_next.lamp_green  = 1'b1;
        act_next.start_led   = 1'b1;
      end
      S_TRANSPORT: begin
        act_next.lamp_red    = 1'b0;
        act_next.lamp_yellow = 1'b0;
        act_next.start_led   = 1'b0;
        act_next.drive_right = 1'b1;
        act_next.lamp_green  = 1'b1;
      end
      S_METALDET: begin
        act_next.drive_right = 1'b0;
        act_next.lamp_red    = 1'b0;
        act_next.lamp_yellow = 1'b0;
        act_next.lamp_green  = 1'b1;
      end
      S_NONMETAL: begin
        act_next.lamp_red    = 1'b0;
        act_next.lamp_yellow = 1'b0;
        act_next.start_led   = 1'b0;
        act_next.drive_right = 1'b1;
        act_next.lamp_green  = 1'b1;
        act_next.gate_open   = 1'b1;
      end
      S_ENDREACHED: begin
        act_next.drive_right = 1'b0;
        act_next.lamp_red    = 1'b0;
        act_next.lamp_yellow = 1'b0;
        act_next.gate_open   = 1'b0;
        act_next.start_led   = 1'b1;
        act_next.lamp_green  = blink_phase;
      end
      S_METAL: begin
        act_next.lamp_green  = 1'b0;
        act_next.lamp_red    = 1'b0;
        act_next.drive_right = 1'b1;
        act_next.lamp_yellow = 1'b1;
      end
      S_ERROR: begin
        act_next.drive_right = 1'b0;
        act_next.lamp_green  = 1'b0;
        act_next.lamp_yellow = 1'b0;
        act_next.gate_open   = 1'b0;
        act_next.start_led   = 1'b1;
        act_next.lamp_red    = blink_phase;
      end
      default: begin
        act_next = act;
      end
    endcase
  end

endmodule

// ----- sv/conveyor_sort_controller.sv -----
// ----------------------------------------------------------------------------
// Conveyor sort controller
// Sorting state machine of a belt that diverts metallic parts to a slide and
// passes the rest through a profile check, driving belt, lamps and gate.
// ----------------------------------------------------------------------------
//
//  Channel   Role   Payload
//  -------   ----   ---------------------------------------------------------
//  sensors   sink   start release edge, five station flags, profile done,
//                   2-bit profile verdict, blink phase
//  result    source 4-bit state code, drive, green/red/yellow lamps,
//                   start LED, gate
//
// Each sensor request passes from acceptance into the input register, then
// through the state and actuator logic into the result register. A new
// request is accepted every cycle while the result is not stalled; the single
// state register sets that figure, as each request needs the state left by
// the one before it. The result register doubles as the held state, so a
// stalled result holds back only the input register, which still takes one
// request. Synchronous reset puts the machine in its start state with every
// actuator off and the gate closed, and empties both registers.
//
module conveyor_sort_controller (
  input logic       clk,
  input logic       rst,
  csc_sensor_if.sink  sensors,
  csc_result_if.source result
);
  import csc_pkg::*;

  // Input register.
  logic       in_valid;
  sensors_t   in_data;

  // Sorting state and held actuators; these also form the result payload.
  sort_state_t state;
  actuators_t  act;
  logic        out_valid;

  sort_state_t state_next;
  actuators_t  act_next;
  logic        advance;
  logic        take;

  // The request in the input register moves on when the result slot is free
  // or is being emptied in this cycle. No request is taken while in reset.
  assign advance       = in_valid && (!out_valid || result.ready);
  assign sensors.ready = !rst && (!in_valid || advance);
  assign take          = sensors.valid && sensors.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (sensors.ready) begin
      in_valid <= sensors.valid;
    end
    if (take) begin
      in_data.start_released  <= sensors.start_released;
      in_data.item_at_start   <= sensors.item_at_start;
      in_data.item_at_end     <= sensors.item_at_end;
      in_data.item_at_height  <= sensors.item_at_height;
      in_data.item_at_metal   <= sensors.item_at_metal;
      in_data.metal_found     <= sensors.metal_found;
      in_data.item_past_slide <= sensors.item_past_slide;
      in_data.profile_done    <= sensors.profile_done;
      in_data.profile_verdict <= sensors.profile_verdict;
      in_data.blink_phase     <= sensors.blink_phase;
    end
  end

  csc_next_state u_next_state (
    .state      (state),
    .sensors    (in_data),
    .state_next (state_next)
  );

  csc_actuators u_actuators (
    .state_next  (state_next),
    .act         (act),
    .blink_phase (in_data.blink_phase),
    .act_next    (act_next)
  );

  // State and actuators change only as a request passes into the result
  // register, so the held values always match the last result given.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_START;
      act       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        state <= state_next;
        act   <= act_next;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign result.valid       = out_valid;
  assign result.state_code  = state_code_of(state);
  assign result.drive_right = act.drive_right;
  assign result.lamp_green  = act.lamp_green;
  assign result.lamp_red    = act.lamp_red;
  assign result.lamp_yellow = act.lamp_yellow;
  assign result.start_led   = act.start_led;
  assign result.gate_open   = act.gate_open;

endmodule
